[hdl/dsba_pkg.sv]
package dsba_pkg;

   // Field widths.
   localparam int SAMPLE_W = 10;
   localparam int TENTHS_W = 13;

   // Temperature scale: tenths = avg * 1250 / 256, truncated.
   localparam int                  SCALE_W          = 11;
   localparam logic [SCALE_W-1:0]  TEMP_SCALE_NUM   = 11'd1250;
   localparam int                  TEMP_SCALE_SHIFT = 8;
   localparam int                  SCALED_W         = SAMPLE_W + SCALE_W;

   // Threshold values after reset.
   localparam logic [SAMPLE_W-1:0] LIGHT_THRESHOLD_RESET = 10'd250;
   localparam logic [TENTHS_W-1:0] TEMP_THRESHOLD_RESET  = 13'd270;

   typedef enum logic [0:0] {
      REG_LIGHT_THRESHOLD = 1'b0,
      REG_TEMP_THRESHOLD  = 1'b1
   } csr_index_type;

endpackage

[hdl/dsba_accum.sv]
module dsba_accum #(
   parameter int WINDOW = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [dsba_pkg::SAMPLE_W-1:0] sample,
   input  logic                          advance,
   output logic [dsba_pkg::SAMPLE_W-1:0] avg_hold
);
   import dsba_pkg::*;

   localparam int SUM_W   = $clog2(WINDOW * 1023 + 1);
   localparam int CNT_W   = $clog2(WINDOW);
   localparam int L_W     = $clog2(WINDOW);
   localparam int SHIFT   = SUM_W + L_W;
   localparam int RECIP_W = SUM_W + 2;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [CNT_W-1:0]   LAST  = CNT_W'(WINDOW - 1);
   // Rounded-up reciprocal; exact floor(sum / WINDOW) for every sum below 2**SUM_W.
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                done_ff, done_in;
   logic [SUM_W-1:0]    done_sum_ff, done_sum_in;
   logic [SAMPLE_W-1:0] hold_ff, hold_in;
   logic [SUM_W-1:0]    sum_next;
   logic [PROD_W-1:0]   product;

   assign sum_next = sum_ff + SUM_W'(sample);
   assign product  = PROD_W'(done_sum_ff) * PROD_W'(RECIP);

   always_comb begin
      sum_in      = sum_ff;
      count_in    = count_ff;
      done_in     = done_ff;
      done_sum_in = done_sum_ff;
      hold_in     = hold_ff;
      if (accept) begin
         done_sum_in = sum_next;
         if (count_ff == LAST) begin
            sum_in   = '0;
            count_in = '0;
            done_in  = 1'b1;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + 1'b1;
            done_in  = 1'b0;
         end
      end
      // The completed block's average lands in the hold register as its item moves on.
      if (advance && done_ff) begin
         hold_in = product[SHIFT +: SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         done_ff  <= 1'b0;
         hold_ff  <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         done_ff  <= done_in;
         hold_ff  <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      done_sum_ff <= done_sum_in;
   end

   assign avg_hold = hold_ff;

endmodule

[hdl/dual_sensor_block_average_threshold.sv]
// Dual sensor block averager with threshold flags.
// Input channel (req_): one sample tick per transfer, a light and a temperature reading.
// Result channel (rsp_): one result per accepted tick, in order: the held light average,
// the held temperature average scaled to tenths of a degree, and the lamp and heat flags.
// Each channel averages non-overlapping blocks of LIGHT_WINDOW and TEMP_WINDOW ticks; the
// tick that closes a block already reports the new average.
// Configuration (csr_): a write with csr_we high sets a threshold at once; write only
// while no result is outstanding.
// Pipeline: a transferred tick passes through stage s1, stage s2 and the output register,
// where its result is valid. Throughput is one tick per cycle while the receiver does not
// stall: accumulate, reciprocal multiply and temperature scale each have their own pipeline stage.
// Reset clears sums, counts and held averages to zero, empties the pipeline and restores
// the thresholds to 250 and 270.
// When the receiver stalls, the result holds in the output register and the stages behind
// it keep filling; req_ready drops only once every stage holds an item.
module dual_sensor_block_average_threshold #(
   parameter int LIGHT_WINDOW = 16,
   parameter int TEMP_WINDOW  = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dsba_pkg::SAMPLE_W-1:0] req_light_sample,
   input  logic [dsba_pkg::SAMPLE_W-1:0] req_temp_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dsba_pkg::SAMPLE_W-1:0] rsp_light_average,
   output logic [dsba_pkg::TENTHS_W-1:0] rsp_temperature_tenths,
   output logic                          rsp_lamp_on,
   output logic                          rsp_heat_on,
   input  logic                          csr_we,
   input  dsba_pkg::csr_index_type       csr_index,
   input  logic [dsba_pkg::TENTHS_W-1:0] csr_wdata
);
   import dsba_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic                s2_valid_ff, s2_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_adv, s2_adv, s1_adv;
   logic                accept, s1_move, s2_move;
   logic [SAMPLE_W-1:0] light_hold, temp_hold;
   logic [SCALED_W-1:0] scaled;
   logic [TENTHS_W-1:0] tenths;
   logic [SAMPLE_W-1:0] light_thr_ff, light_thr_in;
   logic [TENTHS_W-1:0] temp_thr_ff, temp_thr_in;
   logic [SAMPLE_W-1:0] light_avg_ff, light_avg_in;
   logic [TENTHS_W-1:0] tenths_ff, tenths_in;
   logic                lamp_ff, lamp_in;
   logic                heat_ff, heat_in;

   // Each stage moves on when the stage ahead is empty or moving itself.
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = !s2_valid_ff || out_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;
   assign accept    = req_valid && s1_adv;
   assign s1_move   = s1_valid_ff && s2_adv;
   assign s2_move   = s2_valid_ff && out_adv;

   dsba_accum #(.WINDOW(LIGHT_WINDOW)) u_light (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .sample   (req_light_sample),
      .advance  (s1_move),
      .avg_hold (light_hold)
   );

   dsba_accum #(.WINDOW(TEMP_WINDOW)) u_temp (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .sample   (req_temp_sample),
      .advance  (s1_move),
      .avg_hold (temp_hold)
   );

   assign scaled = SCALED_W'(temp_hold) * SCALED_W'(TEMP_SCALE_NUM);
   assign tenths = scaled[TEMP_SCALE_SHIFT +: TENTHS_W];

   always_comb begin
      s1_valid_in  = s1_adv ? req_valid : s1_valid_ff;
      s2_valid_in  = s2_adv ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = out_adv ? s2_valid_ff : rsp_valid_ff;

      light_avg_in = light_avg_ff;
      tenths_in    = tenths_ff;
      lamp_in      = lamp_ff;
      heat_in      = heat_ff;
      if (s2_move) begin
         light_avg_in = light_hold;
         tenths_in    = tenths;
         lamp_in      = light_hold < light_thr_ff;
         heat_in      = tenths >= temp_thr_ff;
      end

      light_thr_in = light_thr_ff;
      temp_thr_in  = temp_thr_ff;
      if (csr_we) begin
         case (csr_index)
            REG_LIGHT_THRESHOLD: light_thr_in = csr_wdata[SAMPLE_W-1:0];
            REG_TEMP_THRESHOLD:  temp_thr_in  = csr_wdata;
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         light_thr_ff <= LIGHT_THRESHOLD_RESET;
         temp_thr_ff  <= TEMP_THRESHOLD_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         light_thr_ff <= light_thr_in;
         temp_thr_ff  <= temp_thr_in;
      end
   end

   always_ff @(posedge clock) begin
      light_avg_ff <= light_avg_in;
      tenths_ff    <= tenths_in;
      lamp_ff      <= lamp_in;
      heat_ff      <= heat_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_light_average      = light_avg_ff;
   assign rsp_temperature_tenths = tenths_ff;
   assign rsp_lamp_on            = lamp_ff;
   assign rsp_heat_on            = heat_ff;

endmodule

[hdl/dsba_checker.sv]
module dsba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dsba_pkg::SAMPLE_W-1:0] rsp_light_average,
   input logic [dsba_pkg::TENTHS_W-1:0] rsp_temperature_tenths,
   input logic                          rsp_lamp_on,
   input logic                          rsp_heat_on
);
   import dsba_pkg::*;

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result keeps its payload until the transfer.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_light_average)
         && $stable(rsp_temperature_tenths) && $stable(rsp_lamp_on)
         && $stable(rsp_heat_on))
      else $error("stalled result changed");

   // Scaled temperature never exceeds 1023 * 1250 / 256.
   a_tenths_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temperature_tenths <= 13'd4995)
      else $error("temperature tenths out of range");

   // With the output register empty, no stage can be full of stalled work.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the output register is empty");

endmodule

bind dual_sensor_block_average_threshold dsba_checker u_dsba_checker (.*);
